>>> hdl/triangle_tangent_bitangent_macros.svh
// Assertion macros shared by the tangent and bitangent unit.
`ifndef TRIANGLE_TANGENT_BITANGENT_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define TTB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence in the same cycle.
`define TTB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence in the next cycle.
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ttb_pkg.sv
// Shared types, widths and helpers of the tangent and bitangent unit.
package ttb_pkg;
    localparam int CoordW         = 32;
    localparam int DeltaW         = CoordW + 1;
    localparam int ProdW          = 2 * DeltaW;
    localparam int AccW           = ProdW + 2;
    localparam int NormW          = 30;
    localparam int SumW           = 2 * NormW + 2;
    localparam int RootW          = SumW / 2;
    localparam int OutW           = 16;
    localparam int MaxMag         = 32767;
    localparam int NumSteps       = 14;
    localparam int DefOutFracBits = 14;
    localparam int DefQueueDepth  = 2;

    // One triangle as edges and texture deltas, all exact.
    typedef struct packed {
        logic [2:0][DeltaW-1:0] e1;
        logic [2:0][DeltaW-1:0] e2;
        logic [DeltaW-1:0]      d1u;
        logic [DeltaW-1:0]      d1v;
        logic [DeltaW-1:0]      d2u;
        logic [DeltaW-1:0]      d2v;
    } t_tri;

    localparam int TriW = $bits(t_tri);

    function automatic logic signed [DeltaW-1:0] sx(input logic [CoordW-1:0] a);
        sx = {a[CoordW-1], a};
    endfunction
endpackage

>>> hdl/ttb_front.sv
// Front end: collects three vertices and forms edges and texture deltas.
module ttb_front
    import ttb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CoordW-1:0] i_position_x,
    input  logic [CoordW-1:0] i_position_y,
    input  logic [CoordW-1:0] i_position_z,
    input  logic [CoordW-1:0] i_tex_u,
    input  logic [CoordW-1:0] i_tex_v,
    output logic              o_push,
    output t_tri              o_tri,
    input  logic              i_full
);
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic [CoordW-1:0] r_pos [2][3];
    logic [CoordW-1:0] r_tex [2][2];
    logic [CoordW-1:0] p_in  [3];
    logic              accept;
    logic              last;

    assign p_in[0] = i_position_x;
    assign p_in[1] = i_position_y;
    assign p_in[2] = i_position_z;

    // A count of three cannot arise; it closes the triangle like two.
    assign last    = (r_count >= 2'd2);
    assign o_stall = last && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = accept && last;
    assign n_count = last ? 2'd0 : r_count + 2'd1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_tri.e1[i] = sx(r_pos[1][i]) - sx(r_pos[0][i]);
            o_tri.e2[i] = sx(p_in[i]) - sx(r_pos[0][i]);
        end
        o_tri.d1u = sx(r_tex[1][0]) - sx(r_tex[0][0]);
        o_tri.d1v = sx(r_tex[1][1]) - sx(r_tex[0][1]);
        o_tri.d2u = sx(i_tex_u) - sx(r_tex[0][0]);
        o_tri.d2v = sx(i_tex_v) - sx(r_tex[0][1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[r_count[0]][i] <= p_in[i];
            end
            r_tex[r_count[0]][0] <= i_tex_u;
            r_tex[r_count[0]][1] <= i_tex_v;
        end
    end
endmodule

>>> hdl/ttb_fifo.sv
// Short register queue between the front end and the back end.
`include "triangle_tangent_bitangent_macros.svh"
module ttb_fifo
    import ttb_pkg::*;
#(
    parameter int Width = TriW,
    parameter int Depth = DefQueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [Width-1:0] o_data
);
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `TTB_ASSERT_ALWAYS(a_cnt_range, r_cnt <= CntW'(Depth), "queue count beyond depth")
    `TTB_ASSERT_IMPL(a_no_overflow, i_push, !o_full, "triangle pushed into a full queue")
endmodule

>>> hdl/ttb_back.sv
// Back end: cross products, then bit-serial normalization of both vectors.
`include "triangle_tangent_bitangent_macros.svh"
module ttb_back
    import ttb_pkg::*;
#(
    parameter int OUT_FRAC_BITS = DefOutFracBits
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tri_valid,
    input  t_tri                   i_tri,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [OutW-1:0] o_tangent_x,
    output logic signed [OutW-1:0] o_tangent_y,
    output logic signed [OutW-1:0] o_tangent_z,
    output logic signed [OutW-1:0] o_bitangent_x,
    output logic signed [OutW-1:0] o_bitangent_y,
    output logic signed [OutW-1:0] o_bitangent_z,
    output logic                   o_degenerate
);
    localparam int QW    = OUT_FRAC_BITS + 1;
    localparam int NumW  = NormW + OUT_FRAC_BITS + 1;
    localparam int QCntW = $clog2(QW + 1);
    localparam int SqW   = $clog2(RootW + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_LOAD  = 10'b0000000100,
        S_SHIFT = 10'b0000001000,
        S_SQ    = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_DINIT = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_WR    = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    t_tri                    r_tri;
    logic [3:0]              r_k;
    logic signed [ProdW-1:0] r_prod;
    logic signed [ProdW-1:0] r_first;
    logic signed [AccW-1:0]  r_acc [7];
    logic                    r_vec;
    logic [AccW-1:0]         r_m [3];
    logic                    r_neg [3];
    logic [SumW-1:0]         r_sum;
    logic [SumW-1:0]         r_n;
    logic [SumW:0]           r_sq_res;
    logic [SqW-1:0]          r_j;
    logic [RootW-1:0]        r_root;
    logic [RootW-1:0]        r_rem [3];
    logic [QW-1:0]           r_nlo [3];
    logic [QW-1:0]           r_q [3];
    logic [QCntW-1:0]        r_dcnt;
    logic signed [OutW-1:0]  r_res_t [3];
    logic signed [OutW-1:0]  r_res_b [3];
    logic                    r_degen;
    logic                    r_out_valid;
    logic signed [OutW-1:0]  r_o_t [3];
    logic signed [OutW-1:0]  r_o_b [3];
    logic                    r_o_degen;

    logic signed [DeltaW-1:0] mul_a;
    logic signed [DeltaW-1:0] mul_b;
    logic signed [ProdW-1:0]  mul_p;
    logic [3:0]               idx;
    logic signed [AccW-1:0]   diff;
    logic                     det_zero;
    logic signed [AccW-1:0]   comp [3];
    logic                     vec_zero;
    logic [AccW-1:0]          or_m;
    logic                     hi8, hi1, lo8, lo1;
    logic [SumW:0]            sq_bit;
    logic [SumW:0]            sq_trial;
    logic [RootW-1:0]         root_c;
    logic [NumW-1:0]          num [3];
    logic [RootW:0]           dtrial [3];
    logic                     dge [3];
    logic [OutW-2:0]          sat [3];
    logic signed [OutW-1:0]   fin [3];
    logic                     out_free;

    assign o_pop    = (r_state == S_IDLE) && i_tri_valid;
    assign out_free = !r_out_valid || !i_stall;

    // One shared multiplier: cross products first, then squares.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SQ) begin
            case (r_k)
                4'd0: begin
                    mul_a = DeltaW'(r_m[0][NormW-1:0]);
                    mul_b = DeltaW'(r_m[0][NormW-1:0]);
                end
                4'd1: begin
                    mul_a = DeltaW'(r_m[1][NormW-1:0]);
                    mul_b = DeltaW'(r_m[1][NormW-1:0]);
                end
                4'd2: begin
                    mul_a = DeltaW'(r_m[2][NormW-1:0]);
                    mul_b = DeltaW'(r_m[2][NormW-1:0]);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else begin
            case (r_k)
                4'd0:  begin mul_a = r_tri.d1u; mul_b = r_tri.d2v;   end
                4'd1:  begin mul_a = r_tri.d2u; mul_b = r_tri.d1v;   end
                4'd2:  begin mul_a = r_tri.d2v; mul_b = r_tri.e1[0]; end
                4'd3:  begin mul_a = r_tri.d1v; mul_b = r_tri.e2[0]; end
                4'd4:  begin mul_a = r_tri.d2v; mul_b = r_tri.e1[1]; end
                4'd5:  begin mul_a = r_tri.d1v; mul_b = r_tri.e2[1]; end
                4'd6:  begin mul_a = r_tri.d2v; mul_b = r_tri.e1[2]; end
                4'd7:  begin mul_a = r_tri.d1v; mul_b = r_tri.e2[2]; end
                4'd8:  begin mul_a = r_tri.d1u; mul_b = r_tri.e2[0]; end
                4'd9:  begin mul_a = r_tri.d2u; mul_b = r_tri.e1[0]; end
                4'd10: begin mul_a = r_tri.d1u; mul_b = r_tri.e2[1]; end
                4'd11: begin mul_a = r_tri.d2u; mul_b = r_tri.e1[1]; end
                4'd12: begin mul_a = r_tri.d1u; mul_b = r_tri.e2[2]; end
                4'd13: begin mul_a = r_tri.d2u; mul_b = r_tri.e1[2]; end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p    = ProdW'(mul_a) * ProdW'(mul_b);
    assign idx      = r_k - 4'd1;
    assign diff     = AccW'(r_first) - AccW'(r_prod);
    assign det_zero = (r_acc[0] == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comp[i] = r_vec ? r_acc[4 + i] : r_acc[1 + i];
        end
        vec_zero = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
    end

    // Normalizing shift: coarse steps of eight, then single steps.
    assign or_m = r_m[0] | r_m[1] | r_m[2];
    assign hi8  = |or_m[AccW-1:NormW+8];
    assign hi1  = |or_m[AccW-1:NormW];
    assign lo8  = (or_m[NormW-1:NormW-8] == '0);
    assign lo1  = !or_m[NormW-1];

    assign sq_bit   = (SumW+1)'(1) << {r_j, 1'b0};
    assign sq_trial = r_sq_res + sq_bit;
    assign root_c   = (r_sq_res == '0) ? RootW'(1) : r_sq_res[RootW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i]    = (NumW'(r_m[i][NormW-1:0]) << OUT_FRAC_BITS)
                        + NumW'(root_c >> 1);
            dtrial[i] = {r_rem[i], r_nlo[i][QW-1]};
            dge[i]    = (dtrial[i] >= {1'b0, r_root});
            sat[i]    = (32'(r_q[i]) > 32'(MaxMag)) ? (OutW-1)'(MaxMag)
                                                    : (OutW-1)'(r_q[i]);
            fin[i]    = r_neg[i] ? -$signed({1'b0, sat[i]}) : $signed({1'b0, sat[i]});
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_tri_valid) n_state = S_MUL;
            S_MUL: begin
                if (r_k == 4'(NumSteps)) begin
                    n_state = det_zero ? S_OUT : S_LOAD;
                end
            end
            S_LOAD: begin
                if (!vec_zero) begin
                    n_state = S_SHIFT;
                end else if (r_vec) begin
                    n_state = S_OUT;
                end
            end
            S_SHIFT: if (!hi1 && !lo1) n_state = S_SQ;
            S_SQ:    if (r_k == 4'd3) n_state = S_SQRT;
            S_SQRT:  if (r_j == '0) n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_dcnt == QCntW'(QW - 1)) n_state = S_WR;
            S_WR:    n_state = r_vec ? S_OUT : S_LOAD;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tri <= i_tri;
                r_k   <= '0;
            end
            S_MUL: begin
                r_prod <= mul_p;
                r_k    <= r_k + 4'd1;
                if (r_k != '0) begin
                    if (!idx[0]) begin
                        r_first <= r_prod;
                    end else begin
                        r_acc[idx[3:1]] <= diff;
                    end
                end
                if (r_k == 4'(NumSteps)) begin
                    r_vec   <= 1'b0;
                    r_degen <= det_zero;
                    for (int i = 0; i < 3; i++) begin
                        r_res_t[i] <= '0;
                        r_res_b[i] <= '0;
                    end
                end
            end
            S_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= comp[i][AccW-1] ? AccW'(-comp[i]) : AccW'(comp[i]);
                    r_neg[i] <= comp[i][AccW-1] ^ r_acc[0][AccW-1];
                end
                // A zero vector keeps its cleared result.
                if (vec_zero) begin
                    r_vec <= 1'b1;
                end
            end
            S_SHIFT: begin
                r_k <= '0;
                for (int i = 0; i < 3; i++) begin
                    if (hi8) begin
                        r_m[i] <= r_m[i] >> 8;
                    end else if (hi1) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (lo8) begin
                        r_m[i] <= r_m[i] << 8;
                    end else if (lo1) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            S_SQ: begin
                r_prod <= mul_p;
                r_k    <= r_k + 4'd1;
                if (r_k == '0) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= r_sum + r_prod[SumW-1:0];
                end
                r_n      <= r_sum + r_prod[SumW-1:0];
                r_sq_res <= '0;
                r_j      <= SqW'(RootW);
            end
            S_SQRT: begin
                if ({1'b0, r_n} >= sq_trial) begin
                    r_n      <= r_n - sq_trial[SumW-1:0];
                    r_sq_res <= (r_sq_res >> 1) + sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_j <= r_j - SqW'(1);
            end
            S_DINIT: begin
                r_root <= root_c;
                r_dcnt <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= RootW'(num[i][NumW-1:QW]);
                    r_nlo[i] <= num[i][QW-1:0];
                    r_q[i]   <= '0;
                end
            end
            S_DIV: begin
                r_dcnt <= r_dcnt + QCntW'(1);
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= dge[i] ? RootW'(dtrial[i] - {1'b0, r_root})
                                       : RootW'(dtrial[i]);
                    r_nlo[i] <= r_nlo[i] << 1;
                    r_q[i]   <= {r_q[i][QW-2:0], dge[i]};
                end
            end
            S_WR: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_vec) begin
                        r_res_b[i] <= fin[i];
                    end else begin
                        r_res_t[i] <= fin[i];
                    end
                end
                r_vec <= 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    for (int i = 0; i < 3; i++) begin
                        r_o_t[i] <= r_res_t[i];
                        r_o_b[i] <= r_res_b[i];
                    end
                    r_o_degen <= r_degen;
                end
            end
            default: begin
                r_k <= '0;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_tangent_x   = r_o_t[0];
    assign o_tangent_y   = r_o_t[1];
    assign o_tangent_z   = r_o_t[2];
    assign o_bitangent_x = r_o_b[0];
    assign o_bitangent_y = r_o_b[1];
    assign o_bitangent_z = r_o_b[2];
    assign o_degenerate  = r_o_degen;

    `TTB_ASSERT_IMPL(a_degen_zero, r_out_valid && r_o_degen, (r_o_t[0] == '0) && (r_o_t[1] == '0) && (r_o_t[2] == '0) && (r_o_b[0] == '0) && (r_o_b[1] == '0) && (r_o_b[2] == '0), "degenerate word carries nonzero vectors")
    `TTB_ASSERT_NEXT(a_pop_starts, o_pop, (r_state == S_MUL) && (r_k == '0), "popped triangle did not start the product sequence")
endmodule

>>> hdl/triangle_tangent_bitangent.sv
// Per-triangle tangent and bitangent: vertex intake, queue and normalizing back end.
// Vertices are taken one per cycle while the queue has room; sustained, one triangle per run.
// After its third vertex, a triangle passes the queue and the back end's product sequence;
// unless it is degenerate, each vector then takes a normalizing shift, squares, a bit-serial
// square root and a divider that yields OUT_FRAC_BITS + 1 quotient bits per component.
// Synchronous active-low reset clears the corner count, queue, sequencer and output valid.
module triangle_tangent_bitangent
    import ttb_pkg::*;
#(
    parameter int OUT_FRAC_BITS = DefOutFracBits,
    parameter int QUEUE_DEPTH   = DefQueueDepth
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [CoordW-1:0] i_position_x,
    input  logic signed [CoordW-1:0] i_position_y,
    input  logic signed [CoordW-1:0] i_position_z,
    input  logic signed [CoordW-1:0] i_tex_u,
    input  logic signed [CoordW-1:0] i_tex_v,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [OutW-1:0] o_tangent_x,
    output logic signed [OutW-1:0] o_tangent_y,
    output logic signed [OutW-1:0] o_tangent_z,
    output logic signed [OutW-1:0] o_bitangent_x,
    output logic signed [OutW-1:0] o_bitangent_y,
    output logic signed [OutW-1:0] o_bitangent_z,
    output logic                   o_degenerate
);
    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_tri tri_in;
    t_tri tri_out;

    ttb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_position_x (i_position_x),
        .i_position_y (i_position_y),
        .i_position_z (i_position_z),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .o_push       (push),
        .o_tri        (tri_in),
        .i_full       (full)
    );

    ttb_fifo #(
        .Width (TriW),
        .Depth (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (tri_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (tri_out)
    );

    ttb_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tri_valid   (q_valid),
        .i_tri         (tri_out),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tangent_x   (o_tangent_x),
        .o_tangent_y   (o_tangent_y),
        .o_tangent_z   (o_tangent_z),
        .o_bitangent_x (o_bitangent_x),
        .o_bitangent_y (o_bitangent_y),
        .o_bitangent_z (o_bitangent_z),
        .o_degenerate  (o_degenerate)
    );
endmodule
